### rtl/clipped_alpha_over_blit_core_defines.svh
// assertion macros shared by the blit core rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CLIPPED_ALPHA_OVER_BLIT_CORE_DEFINES_SVH
`define CLIPPED_ALPHA_OVER_BLIT_CORE_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define CAOB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define CAOB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/caob_pkg.sv
// types, constants and arithmetic helpers for the alpha-over blit core
// no dependencies; imported by clipped_alpha_over_blit_core
package caob_pkg;

    // image store geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = X_W + Y_W;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

    // field widths
    localparam int PIX_W   = 32;
    localparam int DIM_W   = 7;
    localparam int RECT_W  = 13;
    localparam int EXT_W   = RECT_W + 1;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = PIX_W / CH_W;
    localparam int PROD_W  = 2 * CH_W;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(64);
    localparam logic [CH_W-1:0]  ALPHA_MAX = CH_W'(255);

    typedef enum logic [1:0] {
        CMD_WR_SRC = 2'd0,
        CMD_WR_DST = 2'd1,
        CMD_RD_DST = 2'd2,
        CMD_BLIT   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_SRC_EMPTY = 2'd1,
        STATUS_DST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        REG_SRC_W = 2'd0,
        REG_SRC_H = 2'd1,
        REG_DST_W = 2'd2,
        REG_DST_H = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CLIP_SRC,
        ST_CLIP_DST,
        ST_BLIT,
        ST_DRAIN
    } state_t;

    // floor(p / 255) for p < 65535: ((p + 1) * 257) >> 16
    function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W+8:0] t;
        logic [PROD_W+8:0] s;
        t = (PROD_W+9)'(p) + (PROD_W+9)'(1);
        s = (t << 8) + t;
        return s[PROD_W+CH_W-1:PROD_W];
    endfunction

endpackage

### rtl/clipped_alpha_over_blit_core.sv
// porter-duff over blit engine on premultiplied argb32 source and destination stores
// depends on caob_pkg and clipped_alpha_over_blit_core_defines.svh
//
// pixel write commands give their result in the cycle after the transfer; a pixel read
// first passes the read state; a blit runs both clip states, the blit state per clipped
// pixel, then drains the read / multiply / write-back pipeline. throughput: one pixel
// write per cycle unless m_ready stalls; no command is taken in the read state; a blit
// is bounded by the single read port of each image store, one pixel per cycle
// reset: surface size registers go to 64, control and handshakes clear; image stores
// are not initialized and hold garbage until written
`include "clipped_alpha_over_blit_core_defines.svh"

module clipped_alpha_over_blit_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [caob_pkg::PADDR_W-1:0]        paddr,
    input  logic [caob_pkg::PDATA_W-1:0]        pwdata,
    output logic [caob_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,

    // command channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic [caob_pkg::X_W-1:0]            s_pixel_x,
    input  logic [caob_pkg::Y_W-1:0]            s_pixel_y,
    input  logic [caob_pkg::PIX_W-1:0]          s_pixel_value,
    input  logic signed [caob_pkg::RECT_W-1:0]  s_rect_src_x,
    input  logic signed [caob_pkg::RECT_W-1:0]  s_rect_src_y,
    input  logic signed [caob_pkg::RECT_W-1:0]  s_rect_src_w,
    input  logic signed [caob_pkg::RECT_W-1:0]  s_rect_src_h,
    input  logic signed [caob_pkg::RECT_W-1:0]  s_rect_dst_x,
    input  logic signed [caob_pkg::RECT_W-1:0]  s_rect_dst_y,

    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [caob_pkg::PIX_W-1:0]          m_read_pixel,
    output logic [1:0]                          m_status
);
    import caob_pkg::*;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    reg_idx_t         cfg_idx;
    logic             cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= DIM_RESET;
            src_h_reg <= DIM_RESET;
            dst_w_reg <= DIM_RESET;
            dst_h_reg <= DIM_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SRC_W: src_w_reg <= pwdata[DIM_W-1:0];
                REG_SRC_H: src_h_reg <= pwdata[DIM_W-1:0];
                REG_DST_W: dst_w_reg <= pwdata[DIM_W-1:0];
                REG_DST_H: dst_h_reg <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SRC_W: prdata = PDATA_W'(src_w_reg);
            REG_SRC_H: prdata = PDATA_W'(src_h_reg);
            REG_DST_W: prdata = PDATA_W'(dst_w_reg);
            REG_DST_H: prdata = PDATA_W'(dst_h_reg);
            default:   prdata = '0;
        endcase
    end

    // surface sizes saturate at the store size
    logic [DIM_W-1:0] src_w_sat, src_h_sat, dst_w_sat, dst_h_sat;
    assign src_w_sat = (src_w_reg > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : src_w_reg;
    assign src_h_sat = (src_h_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : src_h_reg;
    assign dst_w_sat = (dst_w_reg > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : dst_w_reg;
    assign dst_h_sat = (dst_h_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : dst_h_reg;

    // ------------------------------------------------------------------
    // control state and handshake
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    cmd_t   in_cmd;
    logic   accept;
    logic   m_valid_reg;
    logic   in_inside;

    assign in_cmd    = cmd_t'(s_cmd);
    assign accept    = s_valid && s_ready;
    assign in_inside = ({1'b0, s_pixel_x} < (X_W+1)'(MAX_WIDTH)) &&
                       ({1'b0, s_pixel_y} < (Y_W+1)'(MAX_HEIGHT));

    // captured blit rectangle (payload)
    logic signed [RECT_W-1:0] rsx_reg, rsy_reg, rsw_reg, rsh_reg, rdx_reg, rdy_reg;
    logic                     rd_inside_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            rsx_reg       <= s_rect_src_x;
            rsy_reg       <= s_rect_src_y;
            rsw_reg       <= s_rect_src_w;
            rsh_reg       <= s_rect_src_h;
            rdx_reg       <= s_rect_dst_x;
            rdy_reg       <= s_rect_dst_y;
            rd_inside_reg <= in_inside;
        end
    end

    // ------------------------------------------------------------------
    // source clip: intersect the rectangle with [0,w) x [0,h)
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0] cs_x_lo, cs_x_end, cs_x_lim, cs_x_hi, cs_x_span;
    logic signed [EXT_W-1:0] cs_y_lo, cs_y_end, cs_y_lim, cs_y_hi, cs_y_span;
    logic                    cs_ok;

    always_comb begin
        cs_x_lo   = rsx_reg[RECT_W-1] ? '0 : {rsx_reg[RECT_W-1], rsx_reg};
        cs_x_end  = {rsx_reg[RECT_W-1], rsx_reg} + {rsw_reg[RECT_W-1], rsw_reg};
        cs_x_lim  = {(EXT_W-DIM_W)'(0), src_w_sat};
        cs_x_hi   = (cs_x_end < cs_x_lim) ? cs_x_end : cs_x_lim;
        cs_x_span = cs_x_hi - cs_x_lo;
        cs_y_lo   = rsy_reg[RECT_W-1] ? '0 : {rsy_reg[RECT_W-1], rsy_reg};
        cs_y_end  = {rsy_reg[RECT_W-1], rsy_reg} + {rsh_reg[RECT_W-1], rsh_reg};
        cs_y_lim  = {(EXT_W-DIM_W)'(0), src_h_sat};
        cs_y_hi   = (cs_y_end < cs_y_lim) ? cs_y_end : cs_y_lim;
        cs_y_span = cs_y_hi - cs_y_lo;
        cs_ok     = (cs_x_hi > cs_x_lo) && (cs_y_hi > cs_y_lo);
    end

    // clipped source rectangle, kept for the destination clip
    logic [X_W-1:0]   scx_reg;
    logic [Y_W-1:0]   scy_reg;
    logic [DIM_W-1:0] scw_reg, sch_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLIP_SRC) begin
            scx_reg <= cs_x_lo[X_W-1:0];
            scy_reg <= cs_y_lo[Y_W-1:0];
            scw_reg <= cs_x_span[DIM_W-1:0];
            sch_reg <= cs_y_span[DIM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // destination clip of the clipped rectangle placed at the origin
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0] cd_x_org, cd_x_lo, cd_x_end, cd_x_lim, cd_x_hi, cd_x_span;
    logic signed [EXT_W-1:0] cd_y_org, cd_y_lo, cd_y_end, cd_y_lim, cd_y_hi, cd_y_span;
    logic signed [EXT_W-1:0] off_x, off_y;
    logic                    cd_ok;

    always_comb begin
        cd_x_org  = {rdx_reg[RECT_W-1], rdx_reg};
        cd_x_lo   = rdx_reg[RECT_W-1] ? '0 : cd_x_org;
        cd_x_end  = cd_x_org + {(EXT_W-DIM_W)'(0), scw_reg};
        cd_x_lim  = {(EXT_W-DIM_W)'(0), dst_w_sat};
        cd_x_hi   = (cd_x_end < cd_x_lim) ? cd_x_end : cd_x_lim;
        cd_x_span = cd_x_hi - cd_x_lo;
        cd_y_org  = {rdy_reg[RECT_W-1], rdy_reg};
        cd_y_lo   = rdy_reg[RECT_W-1] ? '0 : cd_y_org;
        cd_y_end  = cd_y_org + {(EXT_W-DIM_W)'(0), sch_reg};
        cd_y_lim  = {(EXT_W-DIM_W)'(0), dst_h_sat};
        cd_y_hi   = (cd_y_end < cd_y_lim) ? cd_y_end : cd_y_lim;
        cd_y_span = cd_y_hi - cd_y_lo;
        cd_ok     = (cd_x_hi > cd_x_lo) && (cd_y_hi > cd_y_lo);
        // source columns and rows that fell off the destination's left or top are skipped
        off_x     = {(EXT_W-X_W)'(0), scx_reg} + cd_x_lo - cd_x_org;
        off_y     = {(EXT_W-Y_W)'(0), scy_reg} + cd_y_lo - cd_y_org;
    end

    // ------------------------------------------------------------------
    // blit walker: one source and one destination address per cycle
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] bcw_reg, bch_reg;
    logic [X_W-1:0]   src_col0_reg, src_col_reg, dst_col0_reg, dst_col_reg;
    logic [Y_W-1:0]   src_row_reg, dst_row_reg;
    logic [X_W-1:0]   col_cnt_reg;
    logic [Y_W-1:0]   row_cnt_reg;
    logic             col_last, row_last, walk_last;

    assign col_last  = ({1'b0, col_cnt_reg} == bcw_reg - DIM_W'(1));
    assign row_last  = ({1'b0, row_cnt_reg} == bch_reg - DIM_W'(1));
    assign walk_last = col_last && row_last;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLIP_DST) begin
            bcw_reg      <= cd_x_span[DIM_W-1:0];
            bch_reg      <= cd_y_span[DIM_W-1:0];
            src_col0_reg <= off_x[X_W-1:0];
            src_col_reg  <= off_x[X_W-1:0];
            src_row_reg  <= off_y[Y_W-1:0];
            dst_col0_reg <= cd_x_lo[X_W-1:0];
            dst_col_reg  <= cd_x_lo[X_W-1:0];
            dst_row_reg  <= cd_y_lo[Y_W-1:0];
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
        end else if (state_reg == ST_BLIT) begin
            if (col_last) begin
                // wrap to the start of the next row
                col_cnt_reg <= '0;
                src_col_reg <= src_col0_reg;
                dst_col_reg <= dst_col0_reg;
                row_cnt_reg <= row_cnt_reg + Y_W'(1);
                src_row_reg <= src_row_reg + Y_W'(1);
                dst_row_reg <= dst_row_reg + Y_W'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + X_W'(1);
                src_col_reg <= src_col_reg + X_W'(1);
                dst_col_reg <= dst_col_reg + X_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // compositing pipeline: read -> multiply -> divide, add, write back
    // ------------------------------------------------------------------
    logic                  p1_valid_reg, p2_valid_reg;
    logic [ADDR_W-1:0]     p1_addr_reg, p2_addr_reg;
    logic [PIX_W-1:0]      p2_src_reg;
    logic [PROD_W-1:0]     prod_reg [NUM_CH];
    logic [PROD_W-1:0]     prod_next [NUM_CH];
    logic [PIX_W-1:0]      blend_pixel;
    logic [PIX_W-1:0]      src_rdata_reg, dst_rdata_reg;
    logic [CH_W-1:0]       inv_alpha;
    logic                  issue;

    assign inv_alpha = ALPHA_MAX - src_rdata_reg[PIX_W-1 -: CH_W];

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            prod_next[i] = PROD_W'(dst_rdata_reg[i*CH_W +: CH_W]) * PROD_W'(inv_alpha);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            // channel sum wraps to 8 bits
            blend_pixel[i*CH_W +: CH_W] = p2_src_reg[i*CH_W +: CH_W] + div255(prod_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= issue;
            // zero source alpha leaves the destination untouched
            p2_valid_reg <= p1_valid_reg && (src_rdata_reg[PIX_W-1 -: CH_W] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        p1_addr_reg <= {dst_row_reg, dst_col_reg};
        p2_addr_reg <= p1_addr_reg;
        p2_src_reg  <= src_rdata_reg;
        for (int i = 0; i < NUM_CH; i++) begin
            prod_reg[i] <= prod_next[i];
        end
    end

    // ------------------------------------------------------------------
    // image stores, one write and one registered read port each
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  src_mem [DEPTH];
    logic [PIX_W-1:0]  dst_mem [DEPTH];
    logic              src_we, dst_we, blend_we;
    logic [ADDR_W-1:0] in_addr, src_raddr, dst_raddr, dst_waddr;
    logic [PIX_W-1:0]  dst_wdata;

    assign in_addr   = {s_pixel_y, s_pixel_x};
    assign src_raddr = {src_row_reg, src_col_reg};
    assign blend_we  = p2_valid_reg;

    always_ff @(posedge aclk) begin
        if (src_we) begin
            src_mem[in_addr] <= s_pixel_value;
        end
        src_rdata_reg <= src_mem[src_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dst_we) begin
            dst_mem[dst_waddr] <= dst_wdata;
        end
        dst_rdata_reg <= dst_mem[dst_raddr];
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_cmd) inside
                        CMD_RD_DST: state_next = ST_READ;
                        CMD_BLIT:   state_next = ST_CLIP_SRC;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:     state_next = ST_IDLE;
            ST_CLIP_SRC: state_next = cs_ok ? ST_CLIP_DST : ST_IDLE;
            ST_CLIP_DST: state_next = cd_ok ? ST_BLIT : ST_IDLE;
            ST_BLIT: begin
                if (walk_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // outputs of the controller
    // ------------------------------------------------------------------
    logic             out_load;
    logic [PIX_W-1:0] out_pixel;
    status_t          out_status;

    always_comb begin
        s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
        issue      = (state_reg == ST_BLIT);
        src_we     = 1'b0;
        dst_we     = blend_we;
        dst_waddr  = p2_addr_reg;
        dst_wdata  = blend_pixel;
        dst_raddr  = {dst_row_reg, dst_col_reg};
        out_load   = 1'b0;
        out_pixel  = '0;
        out_status = STATUS_DONE;
        unique case (state_reg)
            ST_IDLE: begin
                dst_raddr = in_addr;
                if (accept) begin
                    case (in_cmd) inside
                        CMD_WR_SRC: begin
                            src_we   = in_inside;
                            out_load = 1'b1;
                        end
                        CMD_WR_DST: begin
                            dst_we    = in_inside;
                            dst_waddr = in_addr;
                            dst_wdata = s_pixel_value;
                            out_load  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                out_load  = 1'b1;
                out_pixel = rd_inside_reg ? dst_rdata_reg : '0;
            end
            ST_CLIP_SRC: begin
                out_load   = !cs_ok;
                out_status = STATUS_SRC_EMPTY;
            end
            ST_CLIP_DST: begin
                out_load   = !cd_ok;
                out_status = STATUS_DST_EMPTY;
            end
            ST_BLIT: ;
            ST_DRAIN: begin
                out_load = !p1_valid_reg && !p2_valid_reg;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] m_read_pixel_reg;
    status_t          m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_read_pixel_reg <= out_pixel;
            m_status_reg     <= out_status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_pixel = m_read_pixel_reg;
    assign m_status     = m_status_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `CAOB_ASSERT_IMPLIES(a_blend_only_in_blit, blend_we,
        (state_reg == ST_BLIT) || (state_reg == ST_DRAIN),
        "blend write-back outside a blit")
    `CAOB_ASSERT_IMPLIES(a_accept_pipe_empty, accept,
        !p1_valid_reg && !p2_valid_reg,
        "command transfer while the compositing pipeline is busy")
    `CAOB_ASSERT_IMPLIES(a_no_result_overwrite, out_load,
        !m_valid_reg || m_ready,
        "result register loaded while holding an untaken result")
    `CAOB_ASSERT_NEXT(a_read_goes_to_read, accept && (in_cmd == CMD_RD_DST),
        state_reg == ST_READ,
        "read command did not enter the read state")

endmodule

### verif/tb_clipped_alpha_over_blit_core.sv
`timescale 1ns / 1ps
// self-checking testbench for clipped_alpha_over_blit_core: fills a window of both image
// stores, then drives directed, surface-size and random pixel/blit commands against a predictor
// depends on caob_pkg and the clipped_alpha_over_blit_core rtl

module tb_clipped_alpha_over_blit_core;
    import caob_pkg::*;

    localparam int CLK_PERIOD     = 10;
    // a full 64x64 blit holds the command channel with no transfer at all while it walks
    localparam int WATCHDOG_LIMIT = 25000;
    // drain of the read / multiply / write-back pipeline plus margin
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int OPAQUE         = 255;
    // window at the store origin written in both stores before any read
    localparam int WIN_W          = 10;
    localparam int WIN_H          = 10;
    localparam int MAX_TRIES      = 32;

    // one command as it appears on the s_ ports
    typedef struct {
        cmd_t                     cmd;
        logic [X_W-1:0]           px;
        logic [Y_W-1:0]           py;
        logic [PIX_W-1:0]         value;
        logic signed [RECT_W-1:0] sx;
        logic signed [RECT_W-1:0] sy;
        logic signed [RECT_W-1:0] sw;
        logic signed [RECT_W-1:0] sh;
        logic signed [RECT_W-1:0] dx;
        logic signed [RECT_W-1:0] dy;
    } blit_cmd_t;

    // one result as it appears on the m_ ports, tagged with the command that caused it
    typedef struct {
        cmd_t             cmd;
        logic [PIX_W-1:0] pixel;
        status_t          status;
    } blit_result_t;

    // ------------------------------------------------------------------
    // dut signals; every input is known from time zero
    // ------------------------------------------------------------------
    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     psel          = 1'b0;
    logic                     penable       = 1'b0;
    logic                     pwrite        = 1'b0;
    logic [PADDR_W-1:0]       paddr         = '0;
    logic [PDATA_W-1:0]       pwdata        = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_cmd         = '0;
    logic [X_W-1:0]           s_pixel_x     = '0;
    logic [Y_W-1:0]           s_pixel_y     = '0;
    logic [PIX_W-1:0]         s_pixel_value = '0;
    logic signed [RECT_W-1:0] s_rect_src_x  = '0;
    logic signed [RECT_W-1:0] s_rect_src_y  = '0;
    logic signed [RECT_W-1:0] s_rect_src_w  = '0;
    logic signed [RECT_W-1:0] s_rect_src_h  = '0;
    logic signed [RECT_W-1:0] s_rect_dst_x  = '0;
    logic signed [RECT_W-1:0] s_rect_dst_y  = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [PIX_W-1:0]         m_read_pixel;
    logic [1:0]               m_status;

    // ------------------------------------------------------------------
    // predictor state: mirror of both image stores and the surface sizes
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] src_mirror [DEPTH];
    logic [PIX_W-1:0] dst_mirror [DEPTH];
    // entries written so far; commands never read past them
    bit               src_known [DEPTH];
    bit               dst_known [DEPTH];
    int               surf_dim [4] = '{64, 64, 64, 64};
    blit_result_t     pending_blit_results [$];

    int mismatches       = 0;
    int quiet_cycles     = 0;
    // sender pacing: bursts of random length, with random idle gaps bounded by gap_max
    int burst_left       = 0;
    int gap_max          = 2;
    // receiver pacing: stall percentage changes from phase to phase, phases of random length
    int stall_pct        = 0;
    int stall_phase_left = 0;

    clipped_alpha_over_blit_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_value (s_pixel_value),
        .s_rect_src_x  (s_rect_src_x),
        .s_rect_src_y  (s_rect_src_y),
        .s_rect_src_w  (s_rect_src_w),
        .s_rect_src_h  (s_rect_src_h),
        .s_rect_dst_x  (s_rect_dst_x),
        .s_rect_dst_y  (s_rect_dst_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_pixel  (m_read_pixel),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor: clip of a blit, then one command against the mirrored stores
    // ------------------------------------------------------------------
    // status of the blit and, when it is done, where the walk starts and its size
    function automatic status_t clip_blit(input blit_cmd_t c,
                                          output int offx, output int offy,
                                          output int dx0, output int dy0,
                                          output int wd, output int ht);
        int sw_lim, sh_lim, dw_lim, dh_lim;
        int sx0, sx1, sy0, sy1, dx1, dy1;
        offx = 0;
        offy = 0;
        dx0  = 0;
        dy0  = 0;
        wd   = 0;
        ht   = 0;
        // surface registers above the store size saturate
        sw_lim = (surf_dim[REG_SRC_W] > MAX_WIDTH)  ? MAX_WIDTH  : surf_dim[REG_SRC_W];
        sh_lim = (surf_dim[REG_SRC_H] > MAX_HEIGHT) ? MAX_HEIGHT : surf_dim[REG_SRC_H];
        dw_lim = (surf_dim[REG_DST_W] > MAX_WIDTH)  ? MAX_WIDTH  : surf_dim[REG_DST_W];
        dh_lim = (surf_dim[REG_DST_H] > MAX_HEIGHT) ? MAX_HEIGHT : surf_dim[REG_DST_H];
        // source rectangle against the source surface
        sx0 = (int'(c.sx) > 0) ? int'(c.sx) : 0;
        sy0 = (int'(c.sy) > 0) ? int'(c.sy) : 0;
        sx1 = (int'(c.sx) + int'(c.sw) < sw_lim) ? int'(c.sx) + int'(c.sw) : sw_lim;
        sy1 = (int'(c.sy) + int'(c.sh) < sh_lim) ? int'(c.sy) + int'(c.sh) : sh_lim;
        if (sx1 <= sx0 || sy1 <= sy0)
            return STATUS_SRC_EMPTY;
        // clipped source size placed at the destination origin
        dx0 = (int'(c.dx) > 0) ? int'(c.dx) : 0;
        dy0 = (int'(c.dy) > 0) ? int'(c.dy) : 0;
        dx1 = (int'(c.dx) + (sx1 - sx0) < dw_lim) ? int'(c.dx) + (sx1 - sx0) : dw_lim;
        dy1 = (int'(c.dy) + (sy1 - sy0) < dh_lim) ? int'(c.dy) + (sy1 - sy0) : dh_lim;
        if (dx1 <= dx0 || dy1 <= dy0)
            return STATUS_DST_EMPTY;
        // columns/rows lost off the destination's left/top are skipped
        offx = sx0 + (dx0 - int'(c.dx));
        offy = sy0 + (dy0 - int'(c.dy));
        wd   = dx1 - dx0;
        ht   = dy1 - dy0;
        return STATUS_DONE;
    endfunction

    function automatic blit_result_t execute_blit_cmd(blit_cmd_t c);
        blit_result_t r;
        int offx, offy, dx0, dy0, wd, ht, saddr, daddr, alpha, cs, cd;
        logic [PIX_W-1:0] s, d, o;
        r.cmd    = c.cmd;
        r.pixel  = '0;
        r.status = STATUS_DONE;
        case (c.cmd)
            CMD_WR_SRC: begin
                src_mirror[int'({c.py, c.px})] = c.value;
                src_known[int'({c.py, c.px})]  = 1'b1;
            end
            CMD_WR_DST: begin
                dst_mirror[int'({c.py, c.px})] = c.value;
                dst_known[int'({c.py, c.px})]  = 1'b1;
            end
            CMD_RD_DST: r.pixel = dst_mirror[int'({c.py, c.px})];
            default: begin
                r.status = clip_blit(c, offx, offy, dx0, dy0, wd, ht);
                for (int y = 0; y < ht; y++) begin
                    for (int x = 0; x < wd; x++) begin
                        saddr = (offy + y) * MAX_WIDTH + offx + x;
                        daddr = (dy0 + y) * MAX_WIDTH + dx0 + x;
                        s     = src_mirror[saddr];
                        alpha = s[31:24];
                        if (alpha != 0) begin
                            d = dst_mirror[daddr];
                            for (int ch = 0; ch < NUM_CH; ch++) begin
                                cs = s[ch*CH_W +: CH_W];
                                cd = d[ch*CH_W +: CH_W];
                                // channel sum wraps to 8 bits
                                o[ch*CH_W +: CH_W] =
                                    CH_W'(cs + cd * (OPAQUE - alpha) / OPAQUE);
                            end
                            dst_mirror[daddr] = o;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // true when the command would read a store entry that nothing has written yet
    function automatic bit reads_unwritten(input blit_cmd_t c);
        int offx, offy, dx0, dy0, wd, ht;
        bit hit;
        hit = 1'b0;
        case (c.cmd)
            CMD_RD_DST: hit = !dst_known[int'({c.py, c.px})];
            CMD_BLIT: begin
                if (clip_blit(c, offx, offy, dx0, dy0, wd, ht) == STATUS_DONE) begin
                    for (int y = 0; y < ht; y++)
                        for (int x = 0; x < wd; x++)
                            if (!src_known[(offy + y) * MAX_WIDTH + offx + x] ||
                                !dst_known[(dy0 + y) * MAX_WIDTH + dx0 + x])
                                hit = 1'b1;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    function automatic void report_mismatch(string what, logic [PIX_W-1:0] want,
                                            logic [PIX_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    // pixels lean toward transparent and opaque alpha so skip and copy paths both show up
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: v[31:24] = 8'h00;
            1: v[31:24] = 8'hFF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic signed [RECT_W-1:0] rect_extreme();
        case ($urandom_range(0, 6))
            0: return RECT_W'(-4096);
            1: return RECT_W'(4095);
            2: return RECT_W'(0);
            3: return RECT_W'(-1);
            4: return RECT_W'(1);
            5: return RECT_W'(63);
            default: return RECT_W'(64);
        endcase
    endfunction

    // every field random; blits are mostly small rectangles around the filled window
    function automatic blit_cmd_t raw_cmd();
        blit_cmd_t c;
        int pick;
        c.cmd   = cmd_t'($urandom_range(0, 3));
        c.px    = X_W'($urandom);
        c.py    = Y_W'($urandom);
        c.value = random_pixel();
        c.sx    = RECT_W'($urandom);
        c.sy    = RECT_W'($urandom);
        c.sw    = RECT_W'($urandom);
        c.sh    = RECT_W'($urandom);
        c.dx    = RECT_W'($urandom);
        c.dy    = RECT_W'($urandom);
        pick    = $urandom_range(0, 99);
        if (c.cmd != CMD_BLIT) begin
            // most pixel commands land in the filled window
            if (pick < 75) begin
                c.px = X_W'($urandom_range(0, WIN_W - 1));
                c.py = Y_W'($urandom_range(0, WIN_H - 1));
            end
        end else if (pick < 70) begin
            c.sx = RECT_W'(int'($urandom_range(0, WIN_W + 5)) - 3);
            c.sy = RECT_W'(int'($urandom_range(0, WIN_H + 5)) - 3);
            c.sw = RECT_W'($urandom_range(1, 8));
            c.sh = RECT_W'($urandom_range(1, 8));
            c.dx = RECT_W'(int'($urandom_range(0, WIN_W + 5)) - 3);
            c.dy = RECT_W'(int'($urandom_range(0, WIN_H + 5)) - 3);
        end else if (pick < 78) begin
            // about the whole window in one blit
            c.sx = RECT_W'(int'($urandom_range(0, 4)) - 2);
            c.sy = RECT_W'(int'($urandom_range(0, 4)) - 2);
            c.sw = RECT_W'($urandom_range(WIN_W - 2, WIN_W + 4));
            c.sh = RECT_W'($urandom_range(WIN_H - 2, WIN_H + 4));
            c.dx = RECT_W'(int'($urandom_range(0, 4)) - 2);
            c.dy = RECT_W'(int'($urandom_range(0, 4)) - 2);
        end else if (pick < 90) begin
            c.sx = rect_extreme();
            c.sy = rect_extreme();
            c.sw = rect_extreme();
            c.sh = rect_extreme();
            c.dx = rect_extreme();
            c.dy = rect_extreme();
        end
        // otherwise raw 13-bit noise
        return c;
    endfunction

    // random command that only reads written entries; a write is the fallback
    function automatic blit_cmd_t random_cmd();
        blit_cmd_t c;
        c = raw_cmd();
        for (int tries = 0; tries < MAX_TRIES && reads_unwritten(c); tries++)
            c = raw_cmd();
        if (reads_unwritten(c))
            c.cmd = CMD_WR_DST;
        return c;
    endfunction

    function automatic blit_cmd_t pixel_cmd(cmd_t op, int x, int y, logic [PIX_W-1:0] v);
        blit_cmd_t c;
        c       = raw_cmd();
        c.cmd   = op;
        c.px    = X_W'(x);
        c.py    = Y_W'(y);
        c.value = v;
        return c;
    endfunction

    function automatic blit_cmd_t rect_cmd(int sx, int sy, int sw, int sh, int dx, int dy);
        blit_cmd_t c;
        c     = raw_cmd();
        c.cmd = CMD_BLIT;
        c.sx  = RECT_W'(sx);
        c.sy  = RECT_W'(sy);
        c.sw  = RECT_W'(sw);
        c.sh  = RECT_W'(sh);
        c.dx  = RECT_W'(dx);
        c.dy  = RECT_W'(dy);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // command channel driver; called and returns on a rising edge
    // ------------------------------------------------------------------
    task automatic send_cmd(input blit_cmd_t c);
        int gap;
        s_valid       <= 1'b1;
        s_cmd         <= c.cmd;
        s_pixel_x     <= c.px;
        s_pixel_y     <= c.py;
        s_pixel_value <= c.value;
        s_rect_src_x  <= c.sx;
        s_rect_src_y  <= c.sy;
        s_rect_src_w  <= c.sw;
        s_rect_src_h  <= c.sh;
        s_rect_dst_x  <= c.dx;
        s_rect_dst_y  <= c.dy;
        do @(posedge aclk); while (!s_ready);
        // transfer taken at this edge: predict in acceptance order
        pending_blit_results.push_back(execute_blit_cmd(c));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // sender holds off until every expected result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_blit_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // apb write of one surface register followed by a back-to-back read of it
    task automatic program_surface_reg(input reg_idx_t idx, input int value);
        logic [PDATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        surf_dim[idx] = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        // mid-cycle sample of the access phase
        do @(negedge aclk); while (!pready);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (readback !== PDATA_W'(value))
            report_mismatch($sformatf("%s readback", idx.name()), PDATA_W'(value), readback);
    endtask

    task automatic program_surfaces(input int src_w, input int src_h,
                                    input int dst_w, input int dst_h);
        drain_results();
        program_surface_reg(REG_SRC_W, src_w);
        program_surface_reg(REG_SRC_H, src_h);
        program_surface_reg(REG_DST_W, dst_w);
        program_surface_reg(REG_DST_H, dst_h);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // the window at the origin is written in both stores before anything reads it
    task automatic test_fill_stores();
        gap_max = 2;
        for (int a = 0; a < WIN_W * WIN_H; a++) begin
            send_cmd(pixel_cmd(CMD_WR_SRC, a % WIN_W, a / WIN_W, random_pixel()));
            send_cmd(pixel_cmd(CMD_WR_DST, a % WIN_W, a / WIN_W, random_pixel()));
        end
    endtask

    task automatic test_directed_blits();
        gap_max = 3;
        // opaque source replaces the destination
        send_cmd(pixel_cmd(CMD_WR_SRC, 0, 0, 32'hFFFF_FFFF));
        send_cmd(pixel_cmd(CMD_WR_DST, 0, 0, 32'hFFFF_FFFF));
        send_cmd(rect_cmd(0, 0, 1, 1, 0, 0));
        send_cmd(pixel_cmd(CMD_RD_DST, 0, 0, '0));
        // zero source alpha leaves the destination alone, even with color bits set
        send_cmd(pixel_cmd(CMD_WR_SRC, 62, 63, 32'h00FF_FFFF));
        send_cmd(pixel_cmd(CMD_WR_SRC, 63, 63, 32'h0000_0000));
        send_cmd(pixel_cmd(CMD_WR_DST, 63, 63, 32'h1234_5678));
        send_cmd(pixel_cmd(CMD_WR_DST, 62, 63, 32'h89AB_CDEF));
        send_cmd(rect_cmd(62, 63, 2, 1, 62, 63));
        send_cmd(pixel_cmd(CMD_RD_DST, 63, 63, '0));
        send_cmd(pixel_cmd(CMD_RD_DST, 62, 63, '0));
        // nearly transparent over white: channel sum wraps past 255
        send_cmd(pixel_cmd(CMD_WR_SRC, 1, 0, 32'h01FF_FFFF));
        send_cmd(pixel_cmd(CMD_WR_DST, 1, 0, 32'hFFFF_FFFF));
        send_cmd(rect_cmd(1, 0, 1, 1, 1, 0));
        send_cmd(pixel_cmd(CMD_RD_DST, 1, 0, '0));
        // whole filled window in one blit
        send_cmd(rect_cmd(0, 0, WIN_W, WIN_H, 0, 0));
        // empty source clip: zero width, negative height, off the far and near edges
        send_cmd(rect_cmd(0, 0, 0, 8, 0, 0));
        send_cmd(rect_cmd(0, 0, 8, -4096, 0, 0));
        send_cmd(rect_cmd(4095, 4095, 4095, 4095, 0, 0));
        send_cmd(rect_cmd(-4096, -4096, 4095, 4095, 0, 0));
        // empty destination clip
        send_cmd(rect_cmd(0, 0, 8, 8, 64, 0));
        send_cmd(rect_cmd(0, 0, 8, 8, -4096, -4096));
        // source clipped on the left, destination clipped on the left and top
        send_cmd(rect_cmd(-2, 0, 6, 4, -3, -1));
        send_cmd(pixel_cmd(CMD_RD_DST, 0, 0, '0));
        send_cmd(pixel_cmd(CMD_RD_DST, 0, 2, '0));
    endtask

    // several surface sizes, zero and saturating ones among them, each with random traffic
    task automatic test_surface_sweep();
        int sizes [10][4];
        sizes = '{'{0, 64, 64, 64}, '{64, 0, 64, 64}, '{127, 127, 127, 127},
                  '{64, 64, 0, 64}, '{64, 64, 64, 0}, '{1, 1, 1, 1}, '{17, 5, 40, 63},
                  '{0, 0, 0, 0}, '{0, 0, 0, 0}, '{64, 64, 64, 64}};
        for (int k = 7; k < 9; k++)
            for (int j = 0; j < 4; j++)
                sizes[k][j] = $urandom_range(0, 127);
        for (int k = 0; k < 10; k++) begin
            program_surfaces(sizes[k][0], sizes[k][1], sizes[k][2], sizes[k][3]);
            gap_max = (k % 3 == 0) ? 0 : k % 5;
            repeat (20) send_cmd(random_cmd());
        end
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < 8; seg++) begin
            case ($urandom_range(0, 3))
                0, 1: gap_max = 0;
                2: gap_max = 2;
                default: gap_max = 6;
            endcase
            // mid-run the sender waits for the pipeline to empty completely
            if (seg == 4)
                drain_results();
            repeat (16) send_cmd(random_cmd());
        end
    endtask

    // ------------------------------------------------------------------
    // result checker: each transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        blit_result_t head;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blit_results.size() == 0) begin
                report_mismatch("unexpected result transfer", 'x, m_read_pixel);
            end else begin
                head = pending_blit_results.pop_front();
                if (m_read_pixel !== head.pixel)
                    report_mismatch($sformatf("%s read_pixel", head.cmd.name()),
                                    head.pixel, m_read_pixel);
                if (m_status !== head.status)
                    report_mismatch($sformatf("%s status", head.cmd.name()),
                                    PIX_W'(head.status), PIX_W'(m_status));
            end
        end
    end

    // receiver back-pressure: stall density changes from phase to phase, some phases none
    always @(posedge aclk) begin
        if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(32, 300);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 30;
                3: stall_pct = 70;
                default: stall_pct = 90;
            endcase
        end else begin
            stall_phase_left--;
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_blit_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_stores();
        test_directed_blits();
        test_surface_sweep();
        test_random_traffic();
        drain_results();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
